// ===== design/aldf_pkg.sv =====
// ============================================================================
// aldf_pkg
// Shared types, constants and helpers for the adjacent line dedup filter.
// ============================================================================
package aldf_pkg;

    // default maximum stored line length in bytes
    localparam int LINE_MAX_DEF = 512;

    // character constants
    localparam logic [7:0] NL_BYTE     = 8'd10;
    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_UPPER_Z = 8'h5a;
    localparam logic [7:0] CASE_OFFSET = 8'd32;

    // filter_mode codes
    localparam logic [1:0] MODE_PLAIN  = 2'd0;
    localparam logic [1:0] MODE_COUNT  = 2'd1;
    localparam logic [1:0] MODE_DUPS   = 2'd2;
    localparam logic [1:0] MODE_ICASE  = 2'd3;

    // register index of filter_mode on the config port
    localparam logic REG_FILTER_MODE = 1'b0;

    // saturation limit of the run count
    localparam logic [15:0] RUN_MAX = 16'hffff;

    // input request: one text byte
    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_text;
    } t_in_item;

    // output request: one line-release record
    typedef struct packed {
        logic [15:0] line_number;
        logic [15:0] repeat_count;
        logic        show_count;
        logic        last_record;
    } t_out_item;

    // fold upper case letters to lower case
    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
            return c + CASE_OFFSET;
        end
        return c;
    endfunction

endpackage

// ===== design/aldf_ram.sv =====
// ============================================================================
// aldf_ram
// Generic simple dual port RAM: one write port, one read port, registered read.
// ============================================================================
module aldf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/adjacent_line_dedup_filter.sv =====
// Records of a newline enter the output queue when the newline is accepted.
// Throughput: one byte per cycle unless stalled; each byte's compare against the held
//   line reads the store's registered port and resolves in the cycle after the byte.
// Input stall rises only while three or more records wait in the 4-entry output queue.
// Reset (synchronous, active low) clears all control state and filter_mode;
//   the line store is not cleared.
// ============================================================================
// adjacent_line_dedup_filter
// Streams text bytes, compares each line against the previous one and emits
// line-release records in plain, count, duplicates-only or ignore-case mode.
// ============================================================================
module adjacent_line_dedup_filter
    import aldf_pkg::*;
#(
    parameter int LINE_MAX = LINE_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    // record output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int POS_W  = $clog2(LINE_MAX + 1);
    localparam int DEPTH  = 2 * LINE_MAX;
    localparam int ADDR_W = $clog2(DEPTH);

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    logic [1:0]       r_mode;
    logic             r_held_bank;
    logic [POS_W-1:0] r_held_len;
    logic [POS_W-1:0] r_char_pos;
    logic             r_have_held;
    logic             r_mismatch;
    logic [15:0]      r_run;
    logic [15:0]      r_line_cnt;
    logic [15:0]      r_held_ln;
    // compare stage: byte waiting for held-line data
    logic             r_s1_valid;
    logic             r_s1_force;
    logic [7:0]       r_s1_byte;
    // output queue
    t_out_item        r_fifo [4];
    logic [1:0]       r_wr_ptr;
    logic [1:0]       r_rd_ptr;
    logic [2:0]       r_cnt;

    logic [7:0]       rd_data;

    // ------------------------------------------------------------------
    // config port
    // ------------------------------------------------------------------
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_FILTER_MODE);
    assign prdata = (paddr[2] == REG_FILTER_MODE) ? {30'd0, r_mode} : 32'd0;

    // ------------------------------------------------------------------
    // input acceptance
    // ------------------------------------------------------------------
    logic accept, is_nl, store_byte;
    assign o_in_stall = (r_cnt > 3'd2);
    assign accept     = i_in_valid && !o_in_stall;
    assign is_nl      = (i_in_data.char_byte == NL_BYTE);
    assign store_byte = accept && !is_nl && (r_char_pos < POS_W'(LINE_MAX));

    // store addresses: current line goes to the other bank
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    assign wr_addr = ADDR_W'(r_char_pos) + (r_held_bank ? ADDR_W'(0) : ADDR_W'(LINE_MAX));
    assign rd_addr = ADDR_W'(r_char_pos) + (r_held_bank ? ADDR_W'(LINE_MAX) : ADDR_W'(0));

    aldf_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (store_byte),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_in_data.char_byte),
        .i_rd_en   (store_byte),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // ------------------------------------------------------------------
    // resolve the pending byte compare
    // ------------------------------------------------------------------
    logic [7:0] cmp_a, cmp_p;
    logic       mm_pend, mm_total;
    always_comb begin
        cmp_a = r_s1_byte;
        cmp_p = rd_data;
        if (r_mode == MODE_ICASE) begin
            cmp_a = fold_case(r_s1_byte);
            cmp_p = fold_case(rd_data);
        end
    end
    assign mm_pend  = r_s1_valid && (r_s1_force || (cmp_a != cmp_p));
    assign mm_total = r_mismatch || mm_pend;

    // ------------------------------------------------------------------
    // newline decision and record build
    // ------------------------------------------------------------------
    logic        equal;
    logic [15:0] run_next, held_ln_next;
    logic        rel_run, rel_new, rel_eot;
    t_out_item   rec_run, rec_new, rec_eot, rec_a, rec_b;
    logic        has_a, has_b;
    logic [1:0]  push_n;
    logic        pop;

    always_comb begin
        equal = r_have_held && !mm_total && (r_char_pos == r_held_len);
        if (equal) begin
            run_next     = (r_run == RUN_MAX) ? r_run : r_run + 16'd1;
            held_ln_next = r_held_ln;
        end else begin
            run_next     = 16'd1;
            held_ln_next = r_line_cnt;
        end

        rel_run = r_have_held && !equal &&
                  ((r_mode == MODE_COUNT) || ((r_mode == MODE_DUPS) && (r_run > 16'd1)));
        rel_new = !equal && ((r_mode == MODE_PLAIN) || (r_mode == MODE_ICASE));
        rel_eot = i_in_data.end_of_text &&
                  ((r_mode == MODE_COUNT) || ((r_mode == MODE_DUPS) && (run_next > 16'd1)));

        rec_run.line_number  = r_held_ln;
        rec_run.repeat_count = r_run;
        rec_run.show_count   = (r_mode == MODE_COUNT);
        rec_run.last_record  = 1'b0;

        rec_new.line_number  = r_line_cnt;
        rec_new.repeat_count = 16'd1;
        rec_new.show_count   = 1'b0;
        rec_new.last_record  = 1'b0;

        rec_eot.line_number  = held_ln_next;
        rec_eot.repeat_count = run_next;
        rec_eot.show_count   = (r_mode == MODE_COUNT);
        rec_eot.last_record  = 1'b1;

        // order: run-end or new line first, end-of-text release second
        has_b = (rel_run || rel_new) && rel_eot;
        has_a = rel_run || rel_new || rel_eot;
        if (rel_run) begin
            rec_a = rec_run;
        end else if (rel_new) begin
            rec_a = rec_new;
        end else begin
            rec_a = rec_eot;
        end
        rec_a.last_record = !has_b;
        rec_b = rec_eot;

        push_n = 2'd0;
        if (accept && is_nl) begin
            push_n = {1'b0, has_a} + {1'b0, has_b};
        end
    end

    // ------------------------------------------------------------------
    // line state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_PLAIN;
            r_held_bank <= 1'b0;
            r_held_len  <= '0;
            r_char_pos  <= '0;
            r_have_held <= 1'b0;
            r_mismatch  <= 1'b0;
            r_run       <= 16'd1;
            r_line_cnt  <= 16'd0;
            r_held_ln   <= 16'd0;
            r_s1_valid  <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_mode <= pwdata[1:0];
            end
            r_s1_valid <= store_byte;
            if (accept && is_nl) begin
                r_char_pos <= '0;
                r_mismatch <= 1'b0;
                if (i_in_data.end_of_text) begin
                    // release done above; start a fresh text
                    r_held_bank <= 1'b0;
                    r_held_len  <= '0;
                    r_have_held <= 1'b0;
                    r_run       <= 16'd1;
                    r_line_cnt  <= 16'd0;
                    r_held_ln   <= 16'd0;
                end else begin
                    r_run      <= run_next;
                    r_held_ln  <= held_ln_next;
                    r_line_cnt <= r_line_cnt + 16'd1;
                    if (!equal) begin
                        r_held_bank <= !r_held_bank;
                        r_held_len  <= r_char_pos;
                        r_have_held <= 1'b1;
                    end
                end
            end else begin
                r_mismatch <= mm_total;
                if (store_byte) begin
                    r_char_pos <= r_char_pos + POS_W'(1);
                end
            end
        end
    end

    // compare stage payload
    always_ff @(posedge i_clk) begin
        if (store_byte) begin
            r_s1_byte  <= i_in_data.char_byte;
            r_s1_force <= !r_have_held || (r_char_pos >= r_held_len);
        end
    end

    // ------------------------------------------------------------------
    // output queue
    // ------------------------------------------------------------------
    assign o_out_valid = (r_cnt != 3'd0);
    assign o_out_data  = r_fifo[r_rd_ptr];
    assign pop         = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_cnt    <= 3'd0;
        end else begin
            r_wr_ptr <= r_wr_ptr + push_n;
            r_rd_ptr <= r_rd_ptr + {1'b0, pop};
            r_cnt    <= r_cnt + {1'b0, push_n} - {2'b00, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_fifo[r_wr_ptr] <= rec_a;
        end
        if (push_n == 2'd2) begin
            r_fifo[r_wr_ptr + 2'd1] <= rec_b;
        end
    end

endmodule

// ===== design/aldf_checker.sv =====
// ============================================================================
// aldf_checker
// Port-level checks for the adjacent line dedup filter, bound to the top level.
// ============================================================================
module aldf_checker
    import aldf_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data,
    input logic      pready
);

    // a stalled record stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("record dropped while stalled");

    // a stalled record does not change
    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("record changed while stalled");

    // a run is never empty
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.repeat_count != 16'd0))
        else $error("zero repeat count");

    // queue is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && pready)
        else $error("record offered after reset");

endmodule

bind adjacent_line_dedup_filter aldf_checker u_aldf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data),
    .pready      (pready)
);

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Adjacent line dedup filter testbench
// Streams text bytes through the filter in all four filter modes, predicts
// each line-release record with a local model of the line compare, and checks
// every record field by field under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
    import aldf_pkg::*;

    localparam int          LMAX            = LINE_MAX_DEF;
    localparam int          CYCLE_LIMIT     = 1000000;
    localparam int          SETTLE_CYCLES   = 8;
    localparam int          HOLD_OFF_CYCLES = 300;
    localparam int          PHASE_BYTES     = 30;
    localparam logic [2:0]  MODE_ADDR       = 3'(4 * int'(REG_FILTER_MODE));

    // DUT connections; the inputs are all known from time zero
    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_data  = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_data;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    adjacent_line_dedup_filter uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // run bookkeeping
    int unsigned cycle_count    = 0;
    int unsigned mismatch_count = 0;
    int unsigned bytes_sent     = 0;
    int unsigned records_seen   = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    logic        hold_req       = 1'b0;

    // records still owed by the filter, oldest first
    t_out_item   release_q[$];
    t_out_item   byte_recs[$];

    // line-compare model state
    logic [7:0]  text_mem [0:2*LMAX-1];
    logic        prev_bank;
    int unsigned prev_len;
    int unsigned col;
    logic        diff_seen;
    logic [15:0] run_len;
    logic [15:0] line_ctr;
    logic [15:0] prev_line_no;
    logic        have_prev;
    logic [1:0]  mode_now;

    // random text generator buffers
    logic [7:0]  line_buf[$];
    logic [7:0]  prev_buf[$];

    function automatic void note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
    endfunction

    // ------------------------------------------------------------------
    // Line-compare model
    // ------------------------------------------------------------------
    function automatic void clear_text_state();
        prev_bank    = 1'b0;
        prev_len     = 0;
        col          = 0;
        diff_seen    = 1'b0;
        run_len      = 16'd1;
        line_ctr     = 16'd0;
        prev_line_no = 16'd0;
        have_prev    = 1'b0;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
            return c + CASE_OFFSET;
        end
        return c;
    endfunction

    function automatic t_out_item make_record(input logic [15:0] ln, input logic [15:0] reps,
                                              input logic show);
        t_out_item r;
        r.line_number  = ln;
        r.repeat_count = reps;
        r.show_count   = show;
        r.last_record  = 1'b0;
        return r;
    endfunction

    // release the held run when it ends (count and duplicates modes)
    function automatic void close_run();
        if (mode_now == MODE_COUNT) begin
            byte_recs.push_back(make_record(prev_line_no, run_len, 1'b1));
        end else if (mode_now == MODE_DUPS && run_len > 16'd1) begin
            byte_recs.push_back(make_record(prev_line_no, run_len, 1'b0));
        end
    endfunction

    function automatic void predict_release(input t_in_item req);
        logic [7:0]  a;
        logic [7:0]  b;
        logic        same;
        logic [15:0] this_line;
        byte_recs.delete();
        if (req.char_byte != NL_BYTE) begin
            // store and compare, bytes past the line limit are dropped
            if (col < LMAX) begin
                text_mem[(prev_bank ? 0 : LMAX) + col] = req.char_byte;
                if (!have_prev || col >= prev_len) begin
                    diff_seen = 1'b1;
                end else begin
                    a = req.char_byte;
                    b = text_mem[(prev_bank ? LMAX : 0) + col];
                    if (mode_now == MODE_ICASE) begin
                        a = to_lower(a);
                        b = to_lower(b);
                    end
                    if (a != b) diff_seen = 1'b1;
                end
                col++;
            end
            return;
        end

        // newline: decide equality and release
        this_line = line_ctr;
        same = have_prev && !diff_seen && (col == prev_len);
        if (have_prev && !same) close_run();
        if (same) begin
            if (run_len != RUN_MAX) run_len = run_len + 16'd1;
        end else begin
            prev_bank    = ~prev_bank;
            prev_len     = col;
            prev_line_no = this_line;
            run_len      = 16'd1;
            have_prev    = 1'b1;
        end
        if ((mode_now == MODE_PLAIN || mode_now == MODE_ICASE) && !same) begin
            byte_recs.push_back(make_record(this_line, 16'd1, 1'b0));
        end
        line_ctr  = line_ctr + 16'd1;
        col       = 0;
        diff_seen = 1'b0;
        if (req.end_of_text) begin
            close_run();
            clear_text_state();
        end

        if (byte_recs.size() != 0) begin
            byte_recs[byte_recs.size() - 1].last_record = 1'b1;
        end
        foreach (byte_recs[i]) release_q.push_back(byte_recs[i]);
    endfunction

    // ------------------------------------------------------------------
    // Record checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_records
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            records_seen++;
            if (release_q.size() == 0) begin
                note_mismatch($sformatf("unexpected record line=%0d reps=%0d show=%0b last=%0b",
                    o_out_data.line_number, o_out_data.repeat_count,
                    o_out_data.show_count, o_out_data.last_record));
            end else begin
                want = release_q.pop_front();
                if (o_out_data.line_number  !== want.line_number  ||
                    o_out_data.repeat_count !== want.repeat_count ||
                    o_out_data.show_count   !== want.show_count   ||
                    o_out_data.last_record  !== want.last_record) begin
                    note_mismatch($sformatf(
                        "record line/reps/show/last exp %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
                        want.line_number, want.repeat_count, want.show_count, want.last_record,
                        o_out_data.line_number, o_out_data.repeat_count,
                        o_out_data.show_count, o_out_data.last_record));
                end
            end
        end
    end

    // receiver stall, with a long hold-off on request
    always @(posedge i_clk) begin : drive_out_stall
        logic        hold_ack;
        int unsigned hold_left;
        if (cycle_count == 0) begin
            hold_ack  = hold_req;
            hold_left = 0;
        end
        if (hold_req != hold_ack) begin
            hold_ack  = hold_req;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // run timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Shared stimulus tasks
    // ------------------------------------------------------------------
    // offer one byte request, possibly after idle cycles, until accepted
    task automatic send_byte(input logic [7:0] c, input logic eot);
        t_in_item req;
        req.char_byte   = c;
        req.end_of_text = eot;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_release(req);
        bytes_sent++;
    endtask

    // one newline-terminated line of text
    task automatic send_text(input string s, input logic eot);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
        send_byte(NL_BYTE, eot);
    endtask

    // stop sending and let every owed record come out
    task automatic drain_output();
        i_in_valid <= 1'b0;
        while (release_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write of filter_mode, then read it back
    task automatic set_filter_mode(input logic [1:0] m);
        drain_output();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MODE_ADDR;
        pwdata  <= {30'd0, m};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        mode_now = m;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[1:0] !== m) begin
            note_mismatch($sformatf("filter_mode readback exp=%0d got=%0d", m, prdata[1:0]));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // byte extremes, empty lines, stray end-of-text on a plain byte
    task automatic test_plain_extremes();
        set_filter_mode(MODE_PLAIN);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(NL_BYTE, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(NL_BYTE, 1'b0);
        send_byte(NL_BYTE, 1'b0);
        send_byte("q", 1'b1);
        send_byte(NL_BYTE, 1'b1);
    endtask

    // letters fold, neighbors of the letter range do not
    task automatic test_ignore_case();
        set_filter_mode(MODE_ICASE);
        send_text("AZ", 1'b0);
        send_text("az", 1'b0);
        send_text("@[", 1'b0);
        send_text("`{", 1'b0);
        send_text("`{", 1'b1);
    endtask

    // run ends on a new line and on end of text in the same byte
    task automatic test_count_runs();
        set_filter_mode(MODE_COUNT);
        send_text("ab", 1'b0);
        send_text("ab", 1'b0);
        send_text("c", 1'b0);
        send_byte(NL_BYTE, 1'b1);
    endtask

    task automatic test_duplicates_only();
        set_filter_mode(MODE_DUPS);
        send_text("x", 1'b0);
        send_text("y", 1'b0);
        send_text("y", 1'b0);
        send_text("y", 1'b1);
        send_text("w", 1'b1);
    endtask

    // lines agreeing in their first LMAX bytes compare equal
    task automatic test_long_lines();
        set_filter_mode(MODE_PLAIN);
        for (int i = 0; i < LMAX + 4; i++) send_byte("k", 1'b0);
        send_byte(NL_BYTE, 1'b0);
        for (int i = 0; i < LMAX; i++) send_byte("k", 1'b0);
        for (int i = 0; i < 4; i++) send_byte("m", 1'b0);
        send_byte(NL_BYTE, 1'b0);
        send_text("k", 1'b1);
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        set_filter_mode(MODE_PLAIN);
        hold_req = ~hold_req;
        for (int i = 0; i < 40; i++) send_text((i % 2) ? "b" : "a", 1'b0);
        send_text("e", 1'b1);
    endtask

    function automatic logic [7:0] pick_letter();
        case ($urandom_range(5))
            0: return "a";
            1: return "A";
            2: return "b";
            3: return "B";
            4: return "z";
            default: return "Z";
        endcase
    endfunction

    function automatic logic [7:0] flip_case(input logic [7:0] c);
        if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) return c + CASE_OFFSET;
        if (c >= ASCII_UPPER_A + CASE_OFFSET && c <= ASCII_UPPER_Z + CASE_OFFSET) begin
            return c - CASE_OFFSET;
        end
        return c;
    endfunction

    // mostly repeats and near-repeats of the previous line, some noise
    task automatic send_random_line();
        int unsigned pick;
        int unsigned n;
        logic [7:0]  ch;
        pick = $urandom_range(99);
        line_buf = prev_buf;
        if (pick < 40) begin
            // exact repeat
        end else if (pick < 55) begin
            for (int i = 0; i < line_buf.size(); i++) begin
                if ($urandom_range(1)) line_buf[i] = flip_case(line_buf[i]);
            end
        end else if (pick < 65) begin
            if (line_buf.size() != 0 && $urandom_range(1)) begin
                line_buf[$urandom_range(line_buf.size() - 1)] = pick_letter();
            end else if ($urandom_range(1) || line_buf.size() == 0) begin
                line_buf.push_back(pick_letter());
            end else begin
                void'(line_buf.pop_back());
            end
        end else if (pick < 88) begin
            line_buf.delete();
            n = $urandom_range(6);
            for (int i = 0; i < n; i++) line_buf.push_back(pick_letter());
        end else begin
            line_buf.delete();
            n = $urandom_range(12);
            for (int i = 0; i < n; i++) begin
                ch = 8'($urandom_range(255));
                if (ch == NL_BYTE) ch = ch ^ 8'h01;
                line_buf.push_back(ch);
            end
        end
        for (int i = 0; i < line_buf.size(); i++) begin
            send_byte(line_buf[i], $urandom_range(99) < 3);
        end
        send_byte(NL_BYTE, $urandom_range(99) < 8);
        prev_buf = line_buf;
    endtask

    task automatic test_random_traffic();
        int unsigned phase_idle [4] = '{0, 69, 0, 7};
        int unsigned phase_stall[4] = '{0, 0, 69, 7};
        int unsigned goal;
        for (int p = 0; p < 4; p++) begin
            for (int h = 0; h < 2; h++) begin
                set_filter_mode(2'($urandom_range(3)));
                send_idle_pct  = phase_idle[p];
                recv_stall_pct = phase_stall[p];
                goal = bytes_sent + PHASE_BYTES;
                while (bytes_sent < goal) send_random_line();
            end
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // a final line with no newline is never released
    task automatic test_unterminated_tail();
        set_filter_mode(MODE_COUNT);
        send_text("t", 1'b0);
        send_text("t", 1'b0);
        send_byte("t", 1'b0);
        send_byte("u", 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        clear_text_state();
        mode_now = MODE_PLAIN;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_plain_extremes();
        test_ignore_case();
        test_count_runs();
        test_duplicates_only();
        test_long_lines();
        test_backpressure();
        test_random_traffic();
        test_unterminated_tail();
        drain_output();

        $display("Ran plain, count, duplicates and ignore-case modes with long lines,");
        $display("back-pressure and random idling: %0d bytes, %0d records, %0d mismatches.",
                 bytes_sent, records_seen, mismatch_count);
        if (mismatch_count == 0 && release_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
